>>> sv/pd_servo_norm_saturation_core_assert.svh
// ----------------------------------------------------------------------------
// pd servo norm saturation assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef PD_SERVO_NORM_SATURATION_CORE_ASSERT_SVH
`define PD_SERVO_NORM_SATURATION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PSN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psn assertion failed");

`define PSN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psn assertion failed");

`else

`define PSN_ASSERT(lbl, clk, rst_n, prop)

`define PSN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/psn_pkg.sv
// ----------------------------------------------------------------------------
// psn_pkg
// shared constants and register codes of the pd servo norm saturation core
// ----------------------------------------------------------------------------
package psn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int REG_W         = 31;
  localparam int ROOT_W        = 32;
  localparam int QUOT_W        = 33;

  typedef enum logic [1:0] {
    REG_PROP_GAIN = 2'd0,
    REG_DAMP_GAIN = 2'd1,
    REG_MAX_VEL   = 2'd2,
    REG_MAX_ACCEL = 2'd3
  } reg_idx_e;

  localparam logic [REG_W-1:0] RST_PROP_GAIN = 31'd26214400;
  localparam logic [REG_W-1:0] RST_DAMP_GAIN = 31'd2621440;
  localparam logic [REG_W-1:0] RST_MAX_VEL   = 31'd6554;
  localparam logic [REG_W-1:0] RST_MAX_ACCEL = 31'd0;

endpackage

>>> sv/psn_norm_limit.sv
// ----------------------------------------------------------------------------
// psn_norm_limit
// pipelined euclidean norm limiter: scales a two-axis magnitude vector onto
// a limit when en_i is set and its norm exceeds it, keeping the direction
// ----------------------------------------------------------------------------
module psn_norm_limit import psn_pkg::*; #(
  parameter int VW = 47,
  parameter int LW = 46,
  parameter int SW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          en_i,
  input  logic          x_neg_i,
  input  logic          y_neg_i,
  input  logic [VW-1:0] x_mag_i,
  input  logic [VW-1:0] y_mag_i,
  input  logic [LW-1:0] lim_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic          hit_o,
  output logic          x_neg_o,
  output logic          y_neg_o,
  output logic [VW-1:0] x_mag_o,
  output logic [VW-1:0] y_mag_o,
  output logic [SW-1:0] side_o
);

  localparam int NK   = $clog2(VW - 30);
  localparam int SQ_N = ROOT_W;
  localparam int DV_N = QUOT_W;

  typedef struct packed {
    logic          en;
    logic          xn;
    logic          yn;
    logic [VW-1:0] ux;
    logic [VW-1:0] uy;
    logic [63:0]   lim;
    logic [SW-1:0] side;
  } carry_t;

  // shift search
  logic          sh_v_q [NK+1];
  carry_t        sh_c_q [NK+1];
  logic [VW-1:0] sh_x_q [NK+1];
  logic [VW-1:0] sh_y_q [NK+1];
  logic [63:0]   sh_l_q [NK+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_v_q[0] <= 1'b0;
    end else begin
      sh_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_c_q[0] <= carry_t'{en_i, x_neg_i, y_neg_i, x_mag_i, y_mag_i, 64'(lim_i), side_i};
    sh_x_q[0] <= x_mag_i;
    sh_y_q[0] <= y_mag_i;
    sh_l_q[0] <= 64'(lim_i);
  end

  for (genvar j = 0; j < NK; j++) begin : g_sh
    localparam int SH = 1 << (NK - 1 - j);
    logic big;
    assign big = |((sh_x_q[j] | sh_y_q[j]) >> (SH + 30));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sh_v_q[j+1] <= 1'b0;
      end else begin
        sh_v_q[j+1] <= sh_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sh_c_q[j+1] <= sh_c_q[j];
      sh_x_q[j+1] <= big ? (sh_x_q[j] >> SH) : sh_x_q[j];
      sh_y_q[j+1] <= big ? (sh_y_q[j] >> SH) : sh_y_q[j];
      sh_l_q[j+1] <= big ? (sh_l_q[j] >> SH) : sh_l_q[j];
    end
  end

  // squares
  logic        m_v_q;
  carry_t      m_c_q;
  logic [30:0] m_rx_q;
  logic [30:0] m_ry_q;
  logic [61:0] m_sqx_q;
  logic [61:0] m_sqy_q;
  logic [63:0] m_lr2_q;
  logic        m_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= sh_v_q[NK];
    end
  end

  always_ff @(posedge clk_i) begin
    m_c_q   <= sh_c_q[NK];
    m_rx_q  <= sh_x_q[NK][30:0];
    m_ry_q  <= sh_y_q[NK][30:0];
    m_sqx_q <= sh_x_q[NK][30:0] * sh_x_q[NK][30:0];
    m_sqy_q <= sh_y_q[NK][30:0] * sh_y_q[NK][30:0];
    m_lr2_q <= sh_l_q[NK][31:0] * sh_l_q[NK][31:0];
    m_big_q <= |sh_l_q[NK][63:32];
  end

  // square root, one result bit per stage
  logic              sq_v_q    [SQ_N+1];
  carry_t            sq_c_q    [SQ_N+1];
  logic              sq_hit_q  [SQ_N+1];
  logic [30:0]       sq_rx_q   [SQ_N+1];
  logic [30:0]       sq_ry_q   [SQ_N+1];
  logic [63:0]       sq_rad_q  [SQ_N+1];
  logic [SQ_N+1:0]   sq_rem_q  [SQ_N+1];
  logic [SQ_N-1:0]   sq_root_q [SQ_N+1];
  logic [63:0]       sum;

  assign sum = 64'(m_sqx_q) + 64'(m_sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_c_q[0]    <= m_c_q;
    sq_hit_q[0]  <= m_c_q.en && !m_big_q && (sum > m_lr2_q);
    sq_rx_q[0]   <= m_rx_q;
    sq_ry_q[0]   <= m_ry_q;
    sq_rad_q[0]  <= sum;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    logic [SQ_N+3:0] rn;
    logic [SQ_N+3:0] tr;
    logic            ge;
    assign rn = {sq_rem_q[j], sq_rad_q[j][63:62]};
    assign tr = {2'b00, sq_root_q[j], 2'b01};
    assign ge = rn >= tr;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_c_q[j+1]    <= sq_c_q[j];
      sq_hit_q[j+1]  <= sq_hit_q[j];
      sq_rx_q[j+1]   <= sq_rx_q[j];
      sq_ry_q[j+1]   <= sq_ry_q[j];
      sq_rad_q[j+1]  <= {sq_rad_q[j][61:0], 2'b00};
      sq_rem_q[j+1]  <= ge ? (SQ_N+2)'(rn - tr) : rn[SQ_N+1:0];
      sq_root_q[j+1] <= {sq_root_q[j][SQ_N-2:0], ge};
    end
  end

  // long division of r * 2^32 by the norm, one quotient bit per stage
  logic              dv_v_q  [DV_N+1];
  carry_t            dv_c_q  [DV_N+1];
  logic              dv_hit_q[DV_N+1];
  logic [ROOT_W-1:0] dv_n_q  [DV_N+1];
  logic [ROOT_W-1:0] dv_rx_q [DV_N+1];
  logic [ROOT_W-1:0] dv_ry_q [DV_N+1];
  logic [DV_N-1:0]   dv_dx_q [DV_N+1];
  logic [DV_N-1:0]   dv_dy_q [DV_N+1];
  logic [DV_N-1:0]   dv_qx_q [DV_N+1];
  logic [DV_N-1:0]   dv_qy_q [DV_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_c_q[0]   <= sq_c_q[SQ_N];
    dv_hit_q[0] <= sq_hit_q[SQ_N];
    dv_n_q[0]   <= sq_root_q[SQ_N];
    dv_rx_q[0]  <= ROOT_W'(sq_rx_q[SQ_N] >> 1);
    dv_ry_q[0]  <= ROOT_W'(sq_ry_q[SQ_N] >> 1);
    dv_dx_q[0]  <= {sq_rx_q[SQ_N][0], {(DV_N-1){1'b0}}};
    dv_dy_q[0]  <= {sq_ry_q[SQ_N][0], {(DV_N-1){1'b0}}};
    dv_qx_q[0]  <= '0;
    dv_qy_q[0]  <= '0;
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    logic [ROOT_W:0] tx;
    logic [ROOT_W:0] ty;
    logic [ROOT_W:0] nn;
    logic            gx;
    logic            gy;
    assign nn = {1'b0, dv_n_q[j]};
    assign tx = {dv_rx_q[j], dv_dx_q[j][DV_N-1]};
    assign ty = {dv_ry_q[j], dv_dy_q[j][DV_N-1]};
    assign gx = tx >= nn;
    assign gy = ty >= nn;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_c_q[j+1]   <= dv_c_q[j];
      dv_hit_q[j+1] <= dv_hit_q[j];
      dv_n_q[j+1]   <= dv_n_q[j];
      dv_rx_q[j+1]  <= gx ? ROOT_W'(tx - nn) : tx[ROOT_W-1:0];
      dv_ry_q[j+1]  <= gy ? ROOT_W'(ty - nn) : ty[ROOT_W-1:0];
      dv_dx_q[j+1]  <= {dv_dx_q[j][DV_N-2:0], 1'b0};
      dv_dy_q[j+1]  <= {dv_dy_q[j][DV_N-2:0], 1'b0};
      dv_qx_q[j+1]  <= {dv_qx_q[j][DV_N-2:0], gx};
      dv_qy_q[j+1]  <= {dv_qy_q[j][DV_N-2:0], gy};
    end
  end

  // scale by the limit: q * lim / 2^32 in two partial products
  logic              s_v_q;
  carry_t            s_c_q;
  logic              s_hit_q;
  logic [DV_N+31:0]  s_hx_q;
  logic [DV_N+31:0]  s_lx_q;
  logic [DV_N+31:0]  s_hy_q;
  logic [DV_N+31:0]  s_ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= dv_v_q[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    s_c_q   <= dv_c_q[DV_N];
    s_hit_q <= dv_hit_q[DV_N];
    s_hx_q  <= dv_qx_q[DV_N] * dv_c_q[DV_N].lim[63:32];
    s_lx_q  <= dv_qx_q[DV_N] * dv_c_q[DV_N].lim[31:0];
    s_hy_q  <= dv_qy_q[DV_N] * dv_c_q[DV_N].lim[63:32];
    s_ly_q  <= dv_qy_q[DV_N] * dv_c_q[DV_N].lim[31:0];
  end

  // output
  logic [DV_N+31:0] mx;
  logic [DV_N+31:0] my;
  logic             o_v_q;
  logic             o_hit_q;
  logic             o_xn_q;
  logic             o_yn_q;
  logic [VW-1:0]    o_x_q;
  logic [VW-1:0]    o_y_q;
  logic [SW-1:0]    o_side_q;

  assign mx = s_hx_q + (s_lx_q >> 32);
  assign my = s_hy_q + (s_ly_q >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_hit_q  <= s_hit_q;
    o_xn_q   <= s_c_q.xn;
    o_yn_q   <= s_c_q.yn;
    o_x_q    <= s_hit_q ? VW'(mx) : s_c_q.ux;
    o_y_q    <= s_hit_q ? VW'(my) : s_c_q.uy;
    o_side_q <= s_c_q.side;
  end

  assign valid_o = o_v_q;
  assign hit_o   = o_hit_q;
  assign x_neg_o = o_xn_q;
  assign y_neg_o = o_yn_q;
  assign x_mag_o = o_x_q;
  assign y_mag_o = o_y_q;
  assign side_o  = o_side_q;

endmodule

>>> sv/pd_servo_norm_saturation_core.sv
// ----------------------------------------------------------------------------
// pd_servo_norm_saturation_core
// two-axis pd servo with velocity and acceleration norm limits, fixed point
//
//   channel   signals                                   timing
//   request   start_i, busy_o, goal/pos/vel x,y         taken when start_i & !busy_o
//   result    valid_o, accel_x/y, vel/accel_limited     one-cycle strobe, no stall
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i          written on the edge, no wait
//
// one request per cycle through a fully pipelined datapath:
// each norm limiter holds a 32-stage square root and a 33-stage divider
// busy_o stays low, the pipeline never stalls and keeps no state across requests
// reset clears all valid bits and loads the default gains and limits
// ----------------------------------------------------------------------------
`include "pd_servo_norm_saturation_core_assert.svh"

module pd_servo_norm_saturation_core import psn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [DATA_W-1:0] goal_x_i,
  input  logic signed [DATA_W-1:0] goal_y_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] vel_x_i,
  input  logic signed [DATA_W-1:0] vel_y_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [REG_W-1:0]         cfg_wdata_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] accel_x_o,
  output logic signed [DATA_W-1:0] accel_y_o,
  output logic                     vel_limited_o,
  output logic                     accel_limited_o
);

  localparam int VW_V    = 63 - FRAC_BITS;
  localparam int LIM_V_W = 62 - FRAC_BITS;
  localparam int VW_A    = 64 - FRAC_BITS;
  localparam int AW      = 65 - FRAC_BITS;
  localparam logic [REG_W-1:0] ACC_FLOOR = REG_W'((1 << FRAC_BITS) / 100);
  localparam logic [LIM_V_W-1:0] VLIM_RST =
    LIM_V_W'((64'(RST_MAX_VEL) * 64'(RST_DAMP_GAIN)) >> FRAC_BITS);
  localparam logic ACC_EN_RST = RST_MAX_ACCEL > ACC_FLOOR;

  function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic [VW_A-1:0] mag);
    logic [DATA_W-1:0] r;
    if (!neg && (mag > VW_A'(32'h7fff_ffff))) begin
      r = 32'h7fff_ffff;
    end else if (neg && (mag > VW_A'(33'h0_8000_0000))) begin
      r = 32'h8000_0000;
    end else if (neg) begin
      r = -mag[DATA_W-1:0];
    end else begin
      r = mag[DATA_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [REG_W-1:0]   prop_gain_q;
  logic [REG_W-1:0]   damp_gain_q;
  logic [REG_W-1:0]   max_vel_q;
  logic [REG_W-1:0]   max_accel_q;
  logic [LIM_V_W-1:0] vlim_q;
  logic               acc_en_q;
  logic [2*REG_W-1:0] vprod;

  assign vprod = max_vel_q * damp_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= RST_PROP_GAIN;
      damp_gain_q <= RST_DAMP_GAIN;
      max_vel_q   <= RST_MAX_VEL;
      max_accel_q <= RST_MAX_ACCEL;
      vlim_q      <= VLIM_RST;
      acc_en_q    <= ACC_EN_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_PROP_GAIN: prop_gain_q <= cfg_wdata_i;
          REG_DAMP_GAIN: damp_gain_q <= cfg_wdata_i;
          REG_MAX_VEL:   max_vel_q   <= cfg_wdata_i;
          REG_MAX_ACCEL: max_accel_q <= cfg_wdata_i;
          default:       prop_gain_q <= prop_gain_q;
        endcase
      end
      vlim_q   <= LIM_V_W'(vprod >> FRAC_BITS);
      acc_en_q <= max_accel_q > ACC_FLOOR;
    end
  end

  assign busy_o = 1'b0;

  // stage 1: position error
  logic              v1_q;
  logic [DATA_W:0]   dx1_q;
  logic [DATA_W:0]   dy1_q;
  logic [DATA_W-1:0] vx1_q;
  logic [DATA_W-1:0] vy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= {goal_x_i[DATA_W-1], goal_x_i} - {pos_x_i[DATA_W-1], pos_x_i};
    dy1_q <= {goal_y_i[DATA_W-1], goal_y_i} - {pos_y_i[DATA_W-1], pos_y_i};
    vx1_q <= vel_x_i;
    vy1_q <= vel_y_i;
  end

  // stage 2: proportional product
  logic [DATA_W:0]   adx;
  logic [DATA_W:0]   ady;
  logic              v2_q;
  logic              xn2_q;
  logic              yn2_q;
  logic [63:0]       px2_q;
  logic [63:0]       py2_q;
  logic [DATA_W-1:0] vx2_q;
  logic [DATA_W-1:0] vy2_q;

  assign adx = dx1_q[DATA_W] ? -dx1_q : dx1_q;
  assign ady = dy1_q[DATA_W] ? -dy1_q : dy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xn2_q <= dx1_q[DATA_W];
    yn2_q <= dy1_q[DATA_W];
    px2_q <= adx * prop_gain_q;
    py2_q <= ady * prop_gain_q;
    vx2_q <= vx1_q;
    vy2_q <= vy1_q;
  end

  // velocity limit on the proportional term
  logic                vl_v;
  logic                vl_hit;
  logic                vl_xn;
  logic                vl_yn;
  logic [VW_V-1:0]     vl_x;
  logic [VW_V-1:0]     vl_y;
  logic [2*DATA_W-1:0] vl_side;

  psn_norm_limit #(
    .VW (VW_V),
    .LW (LIM_V_W),
    .SW (2*DATA_W)
  ) u_vel_lim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .en_i    (damp_gain_q != '0),
    .x_neg_i (xn2_q),
    .y_neg_i (yn2_q),
    .x_mag_i (px2_q[FRAC_BITS +: VW_V]),
    .y_mag_i (py2_q[FRAC_BITS +: VW_V]),
    .lim_i   (vlim_q),
    .side_i  ({vx2_q, vy2_q}),
    .valid_o (vl_v),
    .hit_o   (vl_hit),
    .x_neg_o (vl_xn),
    .y_neg_o (vl_yn),
    .x_mag_o (vl_x),
    .y_mag_o (vl_y),
    .side_o  (vl_side)
  );

  // stage 4: damping product
  logic [DATA_W-1:0] vx_s;
  logic [DATA_W-1:0] vy_s;
  logic [DATA_W-1:0] avx;
  logic [DATA_W-1:0] avy;
  logic [AW-1:0]     tx_e;
  logic [AW-1:0]     ty_e;
  logic              v4_q;
  logic              vl4_q;
  logic [AW-1:0]     tx4_q;
  logic [AW-1:0]     ty4_q;
  logic              vxn4_q;
  logic              vyn4_q;
  logic [62:0]       dpx4_q;
  logic [62:0]       dpy4_q;

  assign vx_s = vl_side[2*DATA_W-1:DATA_W];
  assign vy_s = vl_side[DATA_W-1:0];
  assign avx  = vx_s[DATA_W-1] ? -vx_s : vx_s;
  assign avy  = vy_s[DATA_W-1] ? -vy_s : vy_s;
  assign tx_e = AW'(vl_x);
  assign ty_e = AW'(vl_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vl_v;
    end
  end

  always_ff @(posedge clk_i) begin
    vl4_q  <= vl_hit;
    tx4_q  <= vl_xn ? -tx_e : tx_e;
    ty4_q  <= vl_yn ? -ty_e : ty_e;
    vxn4_q <= vx_s[DATA_W-1];
    vyn4_q <= vy_s[DATA_W-1];
    dpx4_q <= avx * damp_gain_q;
    dpy4_q <= avy * damp_gain_q;
  end

  // stage 5: signed damping term
  logic [AW-1:0] dmx;
  logic [AW-1:0] dmy;
  logic          v5_q;
  logic          vl5_q;
  logic [AW-1:0] tx5_q;
  logic [AW-1:0] ty5_q;
  logic [AW-1:0] dx5_q;
  logic [AW-1:0] dy5_q;

  assign dmx = AW'(dpx4_q[FRAC_BITS +: 63-FRAC_BITS]);
  assign dmy = AW'(dpy4_q[FRAC_BITS +: 63-FRAC_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vl5_q <= vl4_q;
    tx5_q <= tx4_q;
    ty5_q <= ty4_q;
    dx5_q <= vxn4_q ? -dmx : dmx;
    dy5_q <= vyn4_q ? -dmy : dmy;
  end

  // stage 6: acceleration before limit
  logic          v6_q;
  logic          vl6_q;
  logic [AW-1:0] ax6_q;
  logic [AW-1:0] ay6_q;
  logic [AW-1:0] aax;
  logic [AW-1:0] aay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vl6_q <= vl5_q;
    ax6_q <= tx5_q - dx5_q;
    ay6_q <= ty5_q - dy5_q;
  end

  assign aax = ax6_q[AW-1] ? -ax6_q : ax6_q;
  assign aay = ay6_q[AW-1] ? -ay6_q : ay6_q;

  // acceleration limit
  logic            al_v;
  logic            al_hit;
  logic            al_xn;
  logic            al_yn;
  logic [VW_A-1:0] al_x;
  logic [VW_A-1:0] al_y;
  logic            al_vl;

  psn_norm_limit #(
    .VW (VW_A),
    .LW (REG_W),
    .SW (1)
  ) u_acc_lim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .en_i    (acc_en_q),
    .x_neg_i (ax6_q[AW-1]),
    .y_neg_i (ay6_q[AW-1]),
    .x_mag_i (aax[VW_A-1:0]),
    .y_mag_i (aay[VW_A-1:0]),
    .lim_i   (max_accel_q),
    .side_i  (vl6_q),
    .valid_o (al_v),
    .hit_o   (al_hit),
    .x_neg_o (al_xn),
    .y_neg_o (al_yn),
    .x_mag_o (al_x),
    .y_mag_o (al_y),
    .side_o  (al_vl)
  );

  // output register with saturation
  logic              out_v_q;
  logic [DATA_W-1:0] out_x_q;
  logic [DATA_W-1:0] out_y_q;
  logic              out_vl_q;
  logic              out_al_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= al_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= sat32(al_xn, al_x);
    out_y_q  <= sat32(al_yn, al_y);
    out_vl_q <= al_vl;
    out_al_q <= al_hit;
  end

  assign valid_o         = out_v_q;
  assign accel_x_o       = out_x_q;
  assign accel_y_o       = out_y_q;
  assign vel_limited_o   = out_vl_q;
  assign accel_limited_o = out_al_q;

  `PSN_ASSERT_IMPL(a_vel_lim_needs_kd, clk_i, rst_ni, valid_o && vel_limited_o, damp_gain_q != '0)
  `PSN_ASSERT_IMPL(a_acc_lim_needs_en, clk_i, rst_ni, valid_o && accel_limited_o, acc_en_q)
  `PSN_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o)

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// pd servo norm saturation core: requests driven with and without random gaps through
// several gain and limit settings, each result checked in order against a
// bit-exact predictor of the pd law, the norm limits and output saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import psn_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 170;
  localparam int WDOG_LIMIT = 2000;

  typedef struct {
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic                     vl;
    logic                     al;
  } accel_t;

  class servo_board;
    longint unsigned kp, kd, mv, ma;
    accel_t expected_q[$];
    int errors;

    function new();
      kp = RST_PROP_GAIN; kd = RST_DAMP_GAIN; mv = RST_MAX_VEL; ma = RST_MAX_ACCEL;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [REG_W-1:0] v);
      case (idx)
        REG_PROP_GAIN: kp = v;
        REG_DAMP_GAIN: kd = v;
        REG_MAX_VEL:   mv = v;
        REG_MAX_ACCEL: ma = v;
      endcase
    endfunction

    function longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint gain_mul(longint v, longint unsigned g);
      longint unsigned m;
      m = (magn(v) * g) >> FB;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned scale_comp(longint unsigned r, longint unsigned n,
                                         longint unsigned lim);
      longint unsigned q;
      q = (r << 32) / n;
      return q * (lim >> 32) + ((q * (lim & 64'hFFFF_FFFF)) >> 32);
    endfunction

    function bit clamp_norm(inout longint x, inout longint y, input longint unsigned lim);
      longint unsigned ux, uy, rx, ry, sum, lr, n;
      int s;
      ux = magn(x); uy = magn(y); s = 0;
      while ((ux >> s) >= 64'h8000_0000 || (uy >> s) >= 64'h8000_0000) s++;
      rx = ux >> s; ry = uy >> s;
      sum = rx * rx + ry * ry;
      lr = lim >> s;
      if (lr >= 64'h1_0000_0000 || sum <= lr * lr) return 1'b0;
      n = int_sqrt(sum);
      x = x < 0 ? -longint'(scale_comp(rx, n, lim)) : longint'(scale_comp(rx, n, lim));
      y = y < 0 ? -longint'(scale_comp(ry, n, lim)) : longint'(scale_comp(ry, n, lim));
      return 1'b1;
    endfunction

    function logic [DATA_W-1:0] sat32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[DATA_W-1:0];
    endfunction

    function void note_request(longint gx, longint gy, longint px, longint py,
                               longint vx, longint vy);
      longint tx, ty, ax, ay;
      accel_t e;
      e.vl = 0; e.al = 0;
      tx = gain_mul(gx - px, kp);
      ty = gain_mul(gy - py, kp);
      if (kd != 0) e.vl = clamp_norm(tx, ty, (mv * kd) >> FB);
      ax = tx - gain_mul(vx, kd);
      ay = ty - gain_mul(vy, kd);
      if (ma > ((64'd1 << FB) / 100)) e.al = clamp_norm(ax, ay, ma);
      e.ax = sat32(ax);
      e.ay = sat32(ay);
      expected_q.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(accel_t got);
      accel_t e;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = expected_q.pop_front();
      if (got.ax !== e.ax) report($sformatf("accel_x %h exp %h", got.ax, e.ax));
      if (got.ay !== e.ay) report($sformatf("accel_y %h exp %h", got.ay, e.ay));
      if (got.vl !== e.vl) report($sformatf("vel_limited %b exp %b", got.vl, e.vl));
      if (got.al !== e.al) report($sformatf("accel_limited %b exp %b", got.al, e.al));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, busy_o;
  logic signed [DATA_W-1:0] goal_x_i = 0, goal_y_i = 0, pos_x_i = 0, pos_y_i = 0;
  logic signed [DATA_W-1:0] vel_x_i = 0, vel_y_i = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = 0;
  logic [REG_W-1:0] cfg_wdata_i = 0;
  logic valid_o, vel_limited_o, accel_limited_o;
  logic signed [DATA_W-1:0] accel_x_o, accel_y_o;

  servo_board sb = new();
  bit gaps_on = 1;
  int stall_cnt = 0;

  pd_servo_norm_saturation_core uut (.*);

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    accel_t got;
    if (start_i && !busy_o)
      sb.note_request(goal_x_i, goal_y_i, pos_x_i, pos_y_i, vel_x_i, vel_y_i);
    if (valid_o) begin
      got.ax = accel_x_o; got.ay = accel_y_o;
      got.vl = vel_limited_o; got.al = accel_limited_o;
      sb.check_result(got);
    end
    if ((start_i && !busy_o) || valid_o) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt > WDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task send_request(logic [31:0] gx, gy, px, py, vx, vy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    start_i = 1;
    goal_x_i = gx; goal_y_i = gy; pos_x_i = px; pos_y_i = py;
    vel_x_i = vx; vel_y_i = vy;
    do @(posedge clk_i); while (busy_o);
  endtask

  task drain();
    @(negedge clk_i);
    start_i = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [REG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1; cfg_idx_i = idx; cfg_wdata_i = v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task write_all(logic [REG_W-1:0] p, d, v, a);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_DAMP_GAIN, d);
    write_reg(REG_MAX_VEL, v);
    write_reg(REG_MAX_ACCEL, a);
  endtask

  function logic [31:0] rand_field();
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0: r = $urandom;
      1: begin
        r = 32'($urandom & ((64'd1 << $urandom_range(1, 31)) - 1));
        if ($urandom_range(0, 1)) r = -r;
      end
      2: case ($urandom_range(0, 4))
        0: r = 32'h8000_0000;
        1: r = 32'h7FFF_FFFF;
        2: r = 0;
        3: r = 32'hFFFF_FFFF;
        default: r = 1;
      endcase
      default: begin
        r = $urandom & 32'h0003_FFFF;
        if ($urandom_range(0, 1)) r = -r;
      end
    endcase
    return r;
  endfunction

  function logic [REG_W-1:0] rand_reg();
    return REG_W'($urandom & ((64'd1 << $urandom_range(0, 31)) - 1));
  endfunction

  task random_requests(int n);
    logic [31:0] g;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        g = rand_field();
        send_request(g, rand_field(), g, rand_field(), rand_field(), rand_field());
      end else begin
        send_request(rand_field(), rand_field(), rand_field(), rand_field(),
                     rand_field(), rand_field());
      end
    end
  endtask

  localparam logic [31:0] MIN = 32'h8000_0000, MAX = 32'h7FFF_FFFF;

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // defaults after reset
    send_request(MAX, MAX, MIN, MIN, 0, 0);
    send_request(MIN, MIN, MAX, MAX, MAX, MIN);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, MAX, MAX);
    send_request(32'h1_0000, 0, 32'h1_0000, 0, MIN, MIN);
    send_request(32'd100, 32'hFFFF_FF00, 0, 0, 32'd1, 32'hFFFF_FFFF);
    drain();

    // extremes, acceleration limit at its maximum
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(MAX, MIN, MIN, MAX, MAX, MIN);
    send_request(MIN, MAX, MAX, MIN, MIN, MAX);
    send_request(32'd5, 32'd7, 0, 0, 0, 0);
    send_request(MAX, MAX, MAX, MAX, MIN, MIN);
    drain();

    // zero velocity limit, acceleration limit just enabled
    write_all(31'd26214400, 31'd65536, 31'd0, 31'd656);
    send_request(32'd1, 0, 0, 0, 32'd1000, 32'd1000);
    send_request(32'd3, 32'd3, 32'd3, 32'd3, 32'h0001_0000, 0);
    send_request(MIN, MAX, 0, 0, 0, 0);
    drain();

    // zero damping, acceleration limit at its disabling floor
    write_all(31'd65536, 31'd0, 31'd6554, 31'd655);
    send_request(MAX, MIN, MIN, MAX, MAX, MAX);
    send_request(32'h0001_0000, 32'hFFFF_0000, 0, 0, MIN, MAX);
    send_request(0, 0, 0, 0, 0, 0);
    drain();

    // zero proportional gain, damping gain of one, zero limits
    write_all(31'd0, 31'd1, 31'd0, 31'd0);
    send_request(MAX, MIN, 0, 0, MAX, MIN);
    send_request(32'h0010_0000, 0, 0, 0, 32'h0001_0000, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(31'd26214400, 31'd2621440, 31'd6554, 31'd0);
        1: write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        2: write_all(31'd65536, 31'd0, 31'd0, 31'd656);
        3: write_all(rand_reg(), rand_reg(), 31'd0, rand_reg());
        default: write_all(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      endcase
      gaps_on = (ph < 7);
      random_requests(60);
      drain();
    end

    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/psn_pkg.sv
sv/psn_norm_limit.sv
sv/pd_servo_norm_saturation_core.sv
bench/tb.sv
